>>> rtl/spd_pkg.sv
`timescale 1ns / 1ps
package spd_pkg;

	localparam int COLUMNS_DEF = 8;
	localparam int ROWS_DEF    = 8;

	localparam int COL_W  = 3;
	localparam int LVL_W  = 3;
	localparam int ROW_W  = 4;
	localparam int TIME_W = 32;
	localparam int DEC_W  = 16;
	localparam int PCT_W  = 7;
	localparam int QUO_W  = 7;
	// 100 * elapsed with elapsed below a 16-bit decay
	localparam int NUM_W  = DEC_W + PCT_W;
	localparam int ENT_W  = ROW_W + TIME_W;

	localparam logic [DEC_W-1:0] DECAY_RST = DEC_W'(500);
	localparam logic [PCT_W-1:0] PCT_FULL  = PCT_W'(100);
	localparam logic [PCT_W-1:0] PCT_NONE  = '0;
	localparam logic [ROW_W-1:0] ROW_EMPTY = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

>>> rtl/spd_ram.sv
`timescale 1ns / 1ps
module spd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/spd_div.sv
`timescale 1ns / 1ps
module spd_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [spd_pkg::NUM_W-1:0]  num,
	input  logic [spd_pkg::DEC_W-1:0]  den,
	output logic                       done,
	output logic [spd_pkg::QUO_W-1:0]  quot
);
	import spd_pkg::*;

	localparam int CNT_W = (QUO_W > 1) ? $clog2(QUO_W) : 1;

	logic [NUM_W-1:0] rem_q;
	logic [NUM_W-1:0] dsh_q;
	logic [QUO_W-1:0] quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             fits;

	assign fits = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(QUO_W - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// one quotient bit per cycle, most significant first
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsh_q  <= NUM_W'({den, {(QUO_W-1){1'b0}}});
			quot_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			quot_q <= {quot_q[QUO_W-2:0], fits};
			dsh_q  <= dsh_q >> 1;
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

>>> rtl/spectrum_peak_hold_decay.sv
`timescale 1ns / 1ps
// An accepted word goes through ST_EVAL and ST_DONE when a peak is set, dropped or absent,
// and also ST_MUL and ST_DIV while the top pixel fades, where the 7-step serial divider runs.
// A new word is taken only in ST_IDLE, once the last result is in the output register.
// The column state sits in one RAM with a registered read; write-back precedes the next read.
// Reset (arst_n low, asynchronous) clears every column to row 0, time 0, and decay to 500.
module spectrum_peak_hold_decay #(
	parameter int COLUMNS = spd_pkg::COLUMNS_DEF,
	parameter int ROWS    = spd_pkg::ROWS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [spd_pkg::DEC_W-1:0]  decay_ms,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [spd_pkg::COL_W-1:0]  column,
	input  logic [spd_pkg::LVL_W-1:0]  level,
	input  logic [spd_pkg::TIME_W-1:0] now_ms,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [spd_pkg::ROW_W-1:0]  peak_height,
	output logic [spd_pkg::PCT_W-1:0]  top_percent,
	output logic                       new_peak,
	output logic                       dropped,
	output logic                       active
);
	import spd_pkg::*;

	localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

	state_t state_q, state_d;

	logic [DEC_W-1:0]  decay_q;
	logic [COLUMNS-1:0] vld_q;

	logic [AW-1:0]     addr_s1;
	logic [LVL_W-1:0]  lvl_s1;
	logic [TIME_W-1:0] now_s1;
	logic              range_s1;
	logic              vld_s1;

	logic [ENT_W-1:0]  rdata;
	logic              in_acc;
	logic              in_range;
	logic [LVL_W-1:0]  lvl_sat;

	logic signed [ROW_W-1:0] row_rd;
	logic signed [ROW_W-1:0] row_dn;
	logic [TIME_W-1:0] start_rd;
	logic [TIME_W-1:0] elapsed;
	logic [DEC_W-1:0]  dec_eff;

	logic              ev_we;
	logic              ev_fade;
	logic [ROW_W-1:0]  ev_wrow;
	logic [ROW_W-1:0]  ev_height;
	logic [PCT_W-1:0]  ev_pct;
	logic              ev_np;
	logic              ev_dr;
	logic              ev_act;

	logic [DEC_W-1:0]  elapsed_q;
	logic [ROW_W-1:0]  res_height_q;
	logic [PCT_W-1:0]  res_pct_q;
	logic              res_np_q;
	logic              res_dr_q;
	logic              res_act_q;

	logic              out_valid_q;
	logic [ROW_W-1:0]  out_height_q;
	logic [PCT_W-1:0]  out_pct_q;
	logic              out_np_q;
	logic              out_dr_q;
	logic              out_act_q;

	logic [NUM_W-1:0]  div_num;
	logic              div_start;
	logic              div_done;
	logic [QUO_W-1:0]  div_quot;
	logic              ram_we;
	logic              out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign in_range  = (32'(column) < COLUMNS);
	assign lvl_sat   = (32'(level) > ROWS - 1) ? LVL_W'(ROWS - 1) : level;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decay_q <= DECAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			decay_q <= decay_ms;
		end
	end

	spd_ram #(
		.WIDTH(ENT_W),
		.DEPTH(COLUMNS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(addr_s1),
		.wdata({ev_wrow, now_s1}),
		.re   (in_acc),
		.raddr(AW'(column)),
		.rdata(rdata)
	);

	// a column never written reads as row 0, time 0
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (ram_we) begin
			vld_q[addr_s1] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			addr_s1  <= AW'(column);
			lvl_s1   <= lvl_sat;
			now_s1   <= now_ms;
			range_s1 <= in_range;
			vld_s1   <= in_range ? vld_q[AW'(column)] : 1'b0;
		end
	end

	assign row_rd   = vld_s1 ? rdata[TIME_W +: ROW_W] : '0;
	assign start_rd = vld_s1 ? rdata[TIME_W-1:0] : '0;
	assign row_dn   = row_rd - 1'b1;
	assign elapsed  = now_s1 - start_rd;
	assign dec_eff  = (decay_q == '0) ? DEC_W'(1) : decay_q;

	always_comb begin
		ev_we     = 1'b0;
		ev_fade   = 1'b0;
		ev_wrow   = row_rd;
		ev_height = ROW_EMPTY;
		ev_pct    = PCT_NONE;
		ev_np     = 1'b0;
		ev_dr     = 1'b0;
		ev_act    = 1'b0;
		if (!range_s1) begin
			// out-of-range column: report empty, touch nothing
		end else if (lvl_s1 != '0 && row_rd <= $signed({1'b0, lvl_s1})) begin
			ev_we     = 1'b1;
			ev_wrow   = ROW_W'(lvl_s1);
			ev_height = ROW_W'(lvl_s1);
			ev_pct    = PCT_FULL;
			ev_np     = 1'b1;
			ev_act    = 1'b1;
		end else if (row_rd < 0) begin
			// empty column stays empty
		end else if (elapsed >= TIME_W'(dec_eff)) begin
			// fade finished: drop one row and restart the timer
			ev_we     = 1'b1;
			ev_wrow   = row_dn;
			ev_height = row_dn;
			ev_pct    = (row_dn < 0) ? PCT_NONE : PCT_FULL;
			ev_dr     = 1'b1;
			ev_act    = 1'b1;
		end else begin
			ev_fade   = 1'b1;
			ev_height = row_rd;
			ev_act    = 1'b1;
		end
	end

	assign ram_we    = (state_q == ST_EVAL) && ev_we;
	assign div_start = (state_q == ST_MUL);
	assign div_num   = NUM_W'(elapsed_q) * NUM_W'(PCT_FULL);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	spd_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.num   (div_num),
		.den   (dec_eff),
		.done  (div_done),
		.quot  (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (in_acc) state_d = ST_EVAL;
			ST_EVAL: state_d = ev_fade ? ST_MUL : ST_DONE;
			ST_MUL:  state_d = ST_DIV;
			ST_DIV:  if (div_done) state_d = ST_DONE;
			ST_DONE: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EVAL) begin
			elapsed_q    <= elapsed[DEC_W-1:0];
			res_height_q <= ev_height;
			res_pct_q    <= ev_pct;
			res_np_q     <= ev_np;
			res_dr_q     <= ev_dr;
			res_act_q    <= ev_act;
		end else if (state_q == ST_DIV && div_done) begin
			res_pct_q <= PCT_FULL - div_quot;
		end
	end

	// output register: the next word may enter while this one waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_height_q <= res_height_q;
			out_pct_q    <= res_pct_q;
			out_np_q     <= res_np_q;
			out_dr_q     <= res_dr_q;
			out_act_q    <= res_act_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign peak_height = out_height_q;
	assign top_percent = out_pct_q;
	assign new_peak    = out_np_q;
	assign dropped     = out_dr_q;
	assign active      = out_act_q;

endmodule

>>> rtl/spd_checker.sv
`timescale 1ns / 1ps
module spd_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [spd_pkg::ROW_W-1:0]  peak_height,
	input logic [spd_pkg::PCT_W-1:0]  top_percent,
	input logic                       new_peak,
	input logic                       dropped,
	input logic                       active
);
	import spd_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(peak_height) && $stable(top_percent))
		else $error("result word changed while stalled");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> top_percent <= PCT_FULL)
		else $error("brightness above full scale");

	a_new_peak: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && new_peak |-> active && !dropped && top_percent == PCT_FULL
		&& peak_height != ROW_EMPTY && peak_height != '0)
		else $error("new peak word malformed");

	a_idle_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !active |-> peak_height == ROW_EMPTY && top_percent == PCT_NONE
		&& !new_peak && !dropped)
		else $error("inactive column not reported empty");

	a_fading: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && active && !new_peak && !dropped |-> top_percent != PCT_NONE
		&& peak_height != ROW_EMPTY)
		else $error("fading pixel reached zero without drop");

endmodule

bind spectrum_peak_hold_decay spd_checker u_spd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.peak_height(peak_height),
	.top_percent(top_percent),
	.new_peak   (new_peak),
	.dropped    (dropped),
	.active     (active)
);
